@@ rtl/hkvt_pkg.sv @@
// ----------------------------------------------------------------------------
// hkvt_pkg
// Shared types and codes for the hashed key/value table.
// ----------------------------------------------------------------------------
package hkvt_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int HASH_W       = 32;
	localparam int VALUE_W      = 32;
	localparam int BYTE_W       = 8;

	// sdbm fold shifts
	localparam int HASH_SH_A = 6;
	localparam int HASH_SH_B = 16;

	// action codes
	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_GET    = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// one table word: key hash and its value
	typedef struct packed {
		logic [HASH_W-1:0]  hash;
		logic [VALUE_W-1:0] value;
	} entry_t;

endpackage

@@ rtl/hashed_key_value_table.sv @@
// ----------------------------------------------------------------------------
// hashed_key_value_table
// Key bytes fold into an sdbm hash; on the last byte the table of
// (hash, value) entries is scanned linearly and add/get/remove is applied.
// ----------------------------------------------------------------------------
// A non-last key byte is taken with busy low. A last byte holds busy while the
// entries are scanned to a hit or the last valid one, with no scan on an empty
// table (one entry read per cycle, compared in the next cycle). A hit on remove then
// also moves the last entry into the freed slot. done is high in the first cycle
// busy is low. The receiver cannot stall; done is a one-cycle pulse, one word per
// key. Reset clears the running hash, entry count and FSM; memory is not cleared.
// ----------------------------------------------------------------------------
module hashed_key_value_table #(
	parameter int CAPACITY = hkvt_pkg::CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  action,
	input  logic [hkvt_pkg::BYTE_W-1:0]  key_byte,
	input  logic                        key_last,
	input  logic [hkvt_pkg::VALUE_W-1:0] value,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [hkvt_pkg::VALUE_W-1:0] value_res
);
	import hkvt_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// one-hot controller states
	typedef enum logic [4:0] {
		S_IDLE      = 5'b00001,
		S_SCAN      = 5'b00010,
		S_DECIDE    = 5'b00100,
		S_LAST_RD   = 5'b01000,
		S_LAST_WAIT = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic accept;
	logic [HASH_W-1:0] hash_next;

	// latched command for the current key
	logic [HASH_W-1:0]  key_hash_q;
	logic [1:0]         action_q;
	logic [VALUE_W-1:0] value_q;

	// table occupancy and scan pointer
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic [CNT_W-1:0] count_m1;
	logic [IDX_W-1:0] last_idx;
	logic             full;

	// compare stage: lines up with memory read data
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             hit;
	logic             scan_end;

	// scan outcome
	logic               found_q;
	logic [IDX_W-1:0]   slot_q;
	logic [VALUE_W-1:0] found_val_q;

	// memory ports
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	entry_t           mem_rdata;

	// result registers
	logic               done_q;
	logic [1:0]         status_q;
	logic [VALUE_W-1:0] value_res_q;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign done      = done_q;
	assign status    = status_q;
	assign value_res = value_res_q;

	assign count_m1 = count_q - CNT_W'(1);
	assign last_idx = count_m1[IDX_W-1:0];
	assign full     = (count_q == CNT_W'(CAPACITY));

	assign hit      = cmp_vld_s1 && (mem_rdata.hash == key_hash_q);
	assign scan_end = cmp_vld_s1 && (idx_s1 == last_idx);

	hkvt_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.key_byte  (key_byte),
		.key_last  (key_last),
		.hash_next (hash_next)
	);

	hkvt_store #(
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// next state and memory port control
	always_comb begin
		state_d   = state_q;
		mem_raddr = scan_q[IDX_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = slot_q;
		mem_wdata = '{hash: key_hash_q, value: value_q};
		unique case (state_q)
			S_IDLE: begin
				if (accept && key_last) begin
					// empty table: nothing to scan
					state_d = (count_q == '0) ? S_DECIDE : S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit || scan_end) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_IDLE;
				unique case (action_q)
					ACT_ADD: begin
						if (found_q) begin
							mem_we = 1'b1;
						end else if (!full) begin
							// append at the end of the valid slots
							mem_we    = 1'b1;
							mem_waddr = count_q[IDX_W-1:0];
						end
					end
					ACT_REMOVE: begin
						if (found_q) begin
							state_d = S_LAST_RD;
						end
					end
					default: begin
					end
				endcase
			end
			S_LAST_RD: begin
				// fetch the last valid entry to fill the freed slot
				mem_raddr = last_idx;
				state_d   = S_LAST_WAIT;
			end
			S_LAST_WAIT: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			scan_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && key_last) begin
						scan_q     <= '0;
						cmp_vld_s1 <= 1'b0;
						found_q    <= 1'b0;
					end
				end
				S_SCAN: begin
					scan_q     <= scan_q + CNT_W'(1);
					cmp_vld_s1 <= 1'b1;
					if (hit) begin
						found_q <= 1'b1;
					end
				end
				S_DECIDE: begin
					if (!(action_q == ACT_REMOVE && found_q)) begin
						done_q <= 1'b1;
					end
					if (action_q == ACT_ADD && !found_q && !full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				S_LAST_RD: begin
				end
				S_LAST_WAIT: begin
					done_q  <= 1'b1;
					count_q <= count_m1;
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && key_last) begin
			key_hash_q <= hash_next;
			action_q   <= action;
			value_q    <= value;
		end
		if (state_q == S_SCAN) begin
			idx_s1 <= scan_q[IDX_W-1:0];
			if (hit) begin
				slot_q      <= idx_s1;
				found_val_q <= mem_rdata.value;
			end
		end
		if (state_q == S_DECIDE) begin
			status_q    <= ST_OK;
			value_res_q <= '0;
			unique case (action_q)
				ACT_ADD: begin
					if (!found_q && full) begin
						status_q <= ST_FULL;
					end
				end
				ACT_GET: begin
					if (found_q) begin
						value_res_q <= found_val_q;
					end else begin
						status_q <= ST_NOT_FOUND;
					end
				end
				ACT_REMOVE: begin
					if (!found_q) begin
						status_q <= ST_NOT_FOUND;
					end
				end
				default: begin
				end
			endcase
		end
		if (state_q == S_LAST_WAIT) begin
			status_q    <= ST_OK;
			value_res_q <= '0;
		end
	end

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------

	// result word only goes out once the controller is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// every key passes through S_DECIDE before its strobe, so strobes never touch
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result strobes");

	// occupancy never exceeds the table depth
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// a middle key byte is absorbed without raising busy
	a_mid_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !key_last) |=> !busy)
		else $error("busy after a non-last key byte");

endmodule

@@ rtl/hkvt_hash.sv @@
// ----------------------------------------------------------------------------
// hkvt_hash
// Running sdbm hash; folds one key byte per accepted word.
// ----------------------------------------------------------------------------
module hkvt_hash (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [hkvt_pkg::BYTE_W-1:0] key_byte,
	input  logic                       key_last,
	output logic [hkvt_pkg::HASH_W-1:0] hash_next
);
	import hkvt_pkg::*;

	logic [HASH_W-1:0] running_q;

	// byte + (h << 6) + (h << 16) - h, mod 2^32
	assign hash_next = {{(HASH_W-BYTE_W){1'b0}}, key_byte}
		+ (running_q << HASH_SH_A) + (running_q << HASH_SH_B) - running_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
		end else if (accept) begin
			running_q <= key_last ? '0 : hash_next;
		end
	end

endmodule

@@ rtl/hkvt_store.sv @@
// ----------------------------------------------------------------------------
// hkvt_store
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hkvt_store #(
	parameter int DEPTH = hkvt_pkg::CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  hkvt_pkg::entry_t         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output hkvt_pkg::entry_t         rdata
);
	import hkvt_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hashed_key_value_table. Keys are streamed one byte
// word at a time with random start gaps; a scoreboard object tracks the sdbm
// hash and a shadow copy of the table, then checks every done pulse in order.
// ----------------------------------------------------------------------------
module tb;
	import hkvt_pkg::*;

	localparam int TABLE_DEPTH  = CAPACITY_DEF;
	localparam int TOTAL_WORDS  = 600;
	localparam int POOL_KEYS    = 80;
	localparam int KEY_MAX      = 12;
	localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;
	localparam int LIMIT_CYCLES = 400000;
	// no-gap window, counted in accepted words
	localparam int BURST_LO     = 200;
	localparam int BURST_HI     = 340;

	// code the block does not define; still answers with OK / 0
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]         status;
		logic [VALUE_W-1:0] value;
	} reply_t;

	// ------------------------------------------------------------------------
	// Scoreboard: shadow hash register and table, plus the replies still owed.
	// ------------------------------------------------------------------------
	class kv_scoreboard;
		logic [HASH_W-1:0]  run_hash;
		logic [HASH_W-1:0]  slot_hash [TABLE_DEPTH];
		logic [VALUE_W-1:0] slot_val  [TABLE_DEPTH];
		int                 n_slots;
		reply_t             replies_due [$];
		int                 errors, n_words, n_keys, n_checked;
		int                 n_hits, n_misses, n_full, n_unused;

		function new();
			run_hash  = '0;
			n_slots   = 0;
			errors    = 0;
			n_words   = 0;
			n_keys    = 0;
			n_checked = 0;
			n_hits    = 0;
			n_misses  = 0;
			n_full    = 0;
			n_unused  = 0;
		endfunction

		// one accepted word; a last byte queues the reply it must produce
		function void note_word(logic [1:0] act, logic [BYTE_W-1:0] kbyte, logic klast,
				logic [VALUE_W-1:0] val);
			logic [HASH_W-1:0] h;
			int                slot;
			int                i;
			reply_t            r;
			n_words++;
			// sdbm step, wraps mod 2^32; byte taken unsigned
			h = HASH_W'(kbyte) + (run_hash << HASH_SH_A) + (run_hash << HASH_SH_B) - run_hash;
			if (!klast) begin
				run_hash = h;
				return;
			end
			run_hash = '0;
			n_keys++;
			// linear scan, first match wins
			slot = -1;
			for (i = 0; i < n_slots; i++)
				if (slot < 0 && slot_hash[i] == h)
					slot = i;
			r.status = ST_OK;
			r.value  = '0;
			case (act)
				ACT_ADD: begin
					if (slot >= 0)
						slot_val[slot] = val;
					else if (n_slots >= TABLE_DEPTH) begin
						r.status = ST_FULL;
						n_full++;
					end else begin
						slot_hash[n_slots] = h;
						slot_val[n_slots]  = val;
						n_slots++;
					end
				end
				ACT_GET: begin
					if (slot >= 0)
						r.value = slot_val[slot];
					else
						r.status = ST_NOT_FOUND;
				end
				ACT_REMOVE: begin
					// last live entry fills the hole
					if (slot >= 0) begin
						slot_hash[slot] = slot_hash[n_slots-1];
						slot_val[slot]  = slot_val[n_slots-1];
						n_slots--;
					end else
						r.status = ST_NOT_FOUND;
				end
				default: begin
					n_unused++;
				end
			endcase
			if (act != ACT_UNUSED) begin
				if (slot >= 0)
					n_hits++;
				else
					n_misses++;
			end
			replies_due.push_back(r);
		endfunction

		function void check_result(logic [1:0] st, logic [VALUE_W-1:0] v);
			reply_t want;
			if (replies_due.size() == 0) begin
				$display("%0t: reply with none pending: status=%0d value_res=%h",
					$time, st, v);
				errors++;
				return;
			end
			want = replies_due.pop_front();
			n_checked++;
			if (st !== want.status) begin
				$display("%0t: status mismatch: expected %0d, actual %0d",
					$time, want.status, st);
				errors++;
			end
			if (v !== want.value) begin
				$display("%0t: value_res mismatch: expected %h, actual %h",
					$time, want.value, v);
				errors++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT hookup
	// ------------------------------------------------------------------------
	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         action;
	logic [BYTE_W-1:0]  key_byte;
	logic               key_last;
	logic [VALUE_W-1:0] value;
	logic               done;
	logic [1:0]         status;
	logic [VALUE_W-1:0] value_res;

	kv_scoreboard sb;
	int           cycle_count = 0;

	// key pool: byte i of a key sits at bits [8*i +: 8], first byte lowest
	logic [8*KEY_MAX-1:0] pool_key [POOL_KEYS];
	int                   pool_len [POOL_KEYS];

	hashed_key_value_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.action    (action),
		.key_byte  (key_byte),
		.key_last  (key_last),
		.value     (value),
		.done      (done),
		.status    (status),
		.value_res (value_res)
	);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t: timeout, %0d replies still pending", $time, sb.replies_due.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// done is a one-cycle pulse; no backpressure, so just sample it
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(status, value_res);
	end

	// ------------------------------------------------------------------------
	// Drivers. Called at a falling edge, return at a falling edge.
	// ------------------------------------------------------------------------
	function automatic logic [VALUE_W-1:0] rand_value();
		int roll;
		roll = $urandom_range(15);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return $urandom;
	endfunction

	task automatic send_word(input logic [1:0] act, input logic [BYTE_W-1:0] kbyte,
			input logic klast, input logic [VALUE_W-1:0] val);
		int gap;
		// random start gaps, except inside the burst window
		if ((sb.n_words < BURST_LO || sb.n_words >= BURST_HI) && $urandom_range(99) < 37) begin
			gap = $urandom_range(1, 4);
			start    <= 1'b0;
			action   <= 2'($urandom);
			key_byte <= 8'($urandom);
			key_last <= 1'($urandom);
			value    <= $urandom;
			repeat (gap) @(negedge clk);
		end
		start    <= 1'b1;
		action   <= act;
		key_byte <= kbyte;
		key_last <= klast;
		value    <= val;
		// word is taken at the first rising edge with busy low
		do @(posedge clk); while (busy);
		sb.note_word(act, kbyte, klast, val);
		@(negedge clk);
	endtask

	// action and value only matter on the last byte; junk on the others
	task automatic send_key(input logic [8*KEY_MAX-1:0] kb, input int len,
			input logic [1:0] act, input logic [VALUE_W-1:0] val);
		int i;
		for (i = 0; i < len; i++) begin
			if (i == len - 1)
				send_word(act, kb[8*i +: 8], 1'b1, val);
			else
				send_word(2'($urandom), kb[8*i +: 8], 1'b0, $urandom);
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		logic [8*KEY_MAX-1:0] kb;
		logic [1:0]           act;
		int                   klen, idx, roll, phase, fill_idx, i;

		sb = new();
		start    = 1'b0;
		action   = ACT_ADD;
		key_byte = '0;
		key_last = 1'b0;
		value    = '0;
		arst_n   = 1'b0;
		fill_idx = 0;

		// mostly short keys, a few long ones
		for (i = 0; i < POOL_KEYS; i++) begin
			pool_key[i] = {$urandom, $urandom, $urandom};
			pool_len[i] = ($urandom_range(7) == 0) ? $urandom_range(5, KEY_MAX)
				: $urandom_range(1, 4);
		end

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed ---
		// empty table: get and remove both miss
		send_key(96'hFF, 1, ACT_GET, 32'h1234_5678);
		send_key(96'hFF, 1, ACT_REMOVE, '1);
		// zero byte as a one-byte key, zero value
		send_key(96'h00, 1, ACT_ADD, '0);
		send_key(96'hFF_FFFF, 3, ACT_ADD, '1);
		send_key(96'hFF_FFFF, 3, ACT_GET, '0);
		// {00,41} hashes the same as {41}: treated as one key
		send_key(96'h41, 1, ACT_ADD, 32'h5A5A_A5A5);
		send_key(96'h4100, 2, ACT_GET, '0);
		send_key(96'h4100, 2, ACT_ADD, 32'h8000_0001);
		send_key(96'h41, 1, ACT_GET, '1);
		// unused action code
		send_key(96'h01, 1, ACT_UNUSED, '1);
		// remove slot 0; last entry moves down and must still be found
		send_key(96'h00, 1, ACT_REMOVE, '0);
		send_key(96'h41, 1, ACT_GET, '0);
		send_key(96'h00, 1, ACT_REMOVE, '0);
		send_key(96'hFE01_7F80, 4, ACT_GET, '0);

		// --- random ---
		// phases by key count: fill (runs into full), mixed, drain
		while (sb.n_words < TOTAL_WORDS) begin
			phase = sb.n_keys % 240;
			roll  = $urandom_range(99);
			if (roll < 8) begin
				// noise: random bytes, any action code
				kb   = {$urandom, $urandom, $urandom};
				klen = $urandom_range(1, KEY_MAX);
				send_key(kb, klen, 2'($urandom_range(3)), rand_value());
			end else begin
				roll = $urandom_range(99);
				idx  = $urandom_range(POOL_KEYS - 1);
				if (phase < 100) begin
					if (roll < 85) begin
						act = ACT_ADD;
						// walk the pool so distinct keys pile up past capacity
						idx = fill_idx % POOL_KEYS;
						fill_idx++;
					end else if (roll < 95)
						act = ACT_GET;
					else
						act = ACT_REMOVE;
				end else if (phase < 170) begin
					if (roll < 35)
						act = ACT_ADD;
					else if (roll < 70)
						act = ACT_GET;
					else if (roll < 95)
						act = ACT_REMOVE;
					else
						act = ACT_UNUSED;
				end else begin
					if (roll < 55)
						act = ACT_REMOVE;
					else if (roll < 80)
						act = ACT_GET;
					else if (roll < 95)
						act = ACT_ADD;
					else
						act = ACT_UNUSED;
				end
				send_key(pool_key[idx], pool_len[idx], act, rand_value());
			end
		end
		start <= 1'b0;

		// wait out the owed replies, then watch for strays
		while (sb.replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d words in %0d keys, %0d replies checked, %0d unused-code keys",
			sb.n_words, sb.n_keys, sb.n_checked, sb.n_unused);
		$display("Lookups: %0d hits, %0d misses, %0d adds refused on a full table",
			sb.n_hits, sb.n_misses, sb.n_full);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
